/* hw/rtl/fsu_pkg.sv */
`default_nettype none

package fsu_pkg;

  // Stack sizes and the widths that follow from them.
  localparam int DATA_DEPTH   = 32;
  localparam int RETURN_DEPTH = 16;
  localparam int DCW          = $clog2(DATA_DEPTH + 1);
  localparam int RCW          = $clog2(RETURN_DEPTH + 1);
  localparam int WORD_W       = 32;

  // Fixed widths of the result fields.
  localparam int DDEPTH_OUT_W = 6;
  localparam int RDEPTH_OUT_W = 5;

  // The top entries an opcode may rewrite.
  localparam int DATA_TOP_N   = 6;
  localparam int RET_TOP_N    = 2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNDER   = 2'd1,
    ST_OVER    = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_PUSH  = 2'd1,
    REQ_EXEC  = 2'd2
  } req_t;

  typedef enum logic [4:0] {
    OP_DUP       = 5'd0,
    OP_DROP      = 5'd1,
    OP_SWAP      = 5'd2,
    OP_OVER      = 5'd3,
    OP_ROT       = 5'd4,
    OP_TO_R      = 5'd5,
    OP_R_FROM    = 5'd6,
    OP_2DUP      = 5'd7,
    OP_2DROP     = 5'd8,
    OP_2SWAP     = 5'd9,
    OP_2OVER     = 5'd10,
    OP_2ROT      = 5'd11,
    OP_NIP       = 5'd12,
    OP_TUCK      = 5'd13,
    OP_MROT      = 5'd14,
    OP_R_FETCH   = 5'd15,
    OP_2TO_R     = 5'd16,
    OP_2R_FROM   = 5'd17,
    OP_2R_FETCH  = 5'd18
  } op_t;

  // Depth each opcode needs and how far it moves each stack.
  typedef struct packed {
    logic              valid;
    logic [2:0]        need_d;
    logic [1:0]        need_r;
    logic signed [2:0] grow_d;
    logic signed [2:0] grow_r;
  } op_info_t;

  typedef struct packed {
    status_t                   status;
    logic [DDEPTH_OUT_W-1:0]   data_depth;
    logic [RDEPTH_OUT_W-1:0]   return_depth;
    logic [WORD_W-1:0]         top_value;
  } res_t;

  function automatic op_info_t op_info(input logic [4:0] op);
    op_info_t info;
    info = '0;
    info.valid = 1'b1;
    case (op)
      OP_DUP:      begin info.need_d = 3'd1; info.grow_d = 3'sd1;  end
      OP_DROP:     begin info.need_d = 3'd1; info.grow_d = -3'sd1; end
      OP_SWAP:     begin info.need_d = 3'd2; end
      OP_OVER:     begin info.need_d = 3'd2; info.grow_d = 3'sd1;  end
      OP_ROT:      begin info.need_d = 3'd3; end
      OP_TO_R:     begin info.need_d = 3'd1; info.grow_d = -3'sd1; info.grow_r = 3'sd1; end
      OP_R_FROM:   begin info.need_r = 2'd1; info.grow_d = 3'sd1;  info.grow_r = -3'sd1; end
      OP_2DUP:     begin info.need_d = 3'd2; info.grow_d = 3'sd2;  end
      OP_2DROP:    begin info.need_d = 3'd2; info.grow_d = -3'sd2; end
      OP_2SWAP:    begin info.need_d = 3'd4; end
      OP_2OVER:    begin info.need_d = 3'd4; info.grow_d = 3'sd2;  end
      OP_2ROT:     begin info.need_d = 3'd6; end
      OP_NIP:      begin info.need_d = 3'd2; info.grow_d = -3'sd1; end
      OP_TUCK:     begin info.need_d = 3'd2; info.grow_d = 3'sd1;  end
      OP_MROT:     begin info.need_d = 3'd3; end
      OP_R_FETCH:  begin info.need_r = 2'd1; info.grow_d = 3'sd1;  end
      OP_2TO_R:    begin info.need_d = 3'd2; info.grow_d = -3'sd2; info.grow_r = 3'sd2; end
      OP_2R_FROM:  begin info.need_r = 2'd2; info.grow_d = 3'sd2;  info.grow_r = -3'sd2; end
      OP_2R_FETCH: begin info.need_r = 2'd2; info.grow_d = 3'sd2;  end
      default:     begin info.valid = 1'b0; end
    endcase
    return info;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/forth_stack_shuffle_unit.sv */
// A result beat is registered when its request beat is accepted. Throughput: one request
// beat per cycle while in_tready is high; each stack is a shift register with the top at
// entry 0, so a request reads and rewrites only the top entries and shifts the rest.
// A two-entry output buffer (result register plus skid) keeps input flowing under backpressure.
// Reset (rst_n low at a clock edge) empties both stacks and the output buffer; stack
// entries themselves are not cleared, since only entries below the depth are ever read.
`default_nettype none

module forth_stack_shuffle_unit
  import fsu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Request channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,  // [31:0] load_value, [36:32] opcode, [39:37] zero
  input  wire logic [1:0]  in_tuser,  // [1:0] req_type
  // Result channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata, // [5:0] data_depth, [10:6] return_depth,
                                      // [42:11] top_value, [47:43] zero
  output logic [1:0]       out_tuser  // [1:0] status
);

  // Stack storage. Entry 0 is the top of each stack.
  logic [WORD_W-1:0] d_r   [DATA_DEPTH];
  logic [WORD_W-1:0] d_nxt [DATA_DEPTH];
  logic [WORD_W-1:0] r_r   [RETURN_DEPTH];
  logic [WORD_W-1:0] r_nxt [RETURN_DEPTH];
  logic [DCW-1:0]    dcnt_r, dcnt_nxt;
  logic [RCW-1:0]    rcnt_r, rcnt_nxt;

  // Output buffer: the result register and one skid entry behind it.
  res_t out_r, out_nxt, skid_r, skid_nxt;
  logic out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;

  logic              in_acc;
  logic [1:0]        req;
  logic [WORD_W-1:0] load_val;
  logic [4:0]        op;
  op_info_t          info;
  logic              under, over;
  logic              apply;
  logic signed [2:0] gd, gr;
  status_t           status;
  res_t              res;

  assign in_acc   = in_tvalid && in_tready;
  assign req      = in_tuser;
  assign load_val = in_tdata[WORD_W-1:0];
  assign op       = in_tdata[WORD_W+4:WORD_W];
  assign info     = op_info(op);

  // Underflow is checked before overflow, so it wins when both hold.
  always_comb begin
    under = (dcnt_r < DCW'(info.need_d)) || (rcnt_r < RCW'(info.need_r));
    over  = ((info.grow_d > 3'sd0) &&
             (({1'b0, dcnt_r} + (DCW+1)'(info.grow_d[1:0])) > (DCW+1)'(DATA_DEPTH))) ||
            ((info.grow_r > 3'sd0) &&
             (({1'b0, rcnt_r} + (RCW+1)'(info.grow_r[1:0])) > (RCW+1)'(RETURN_DEPTH)));
  end

  // Request decode: the status, whether the stacks move, and how far.
  always_comb begin
    status = ST_OK;
    apply  = 1'b0;
    gd     = 3'sd0;
    gr     = 3'sd0;
    case (req)
      REQ_CLEAR: begin
        status = ST_OK;
      end
      REQ_PUSH: begin
        if (dcnt_r >= DCW'(DATA_DEPTH)) begin
          status = ST_OVER;
        end else begin
          apply = 1'b1;
          gd    = 3'sd1;
        end
      end
      REQ_EXEC: begin
        if (!info.valid) begin
          status = ST_INVALID;
        end else if (under) begin
          status = ST_UNDER;
        end else if (over) begin
          status = ST_OVER;
        end else begin
          apply = 1'b1;
          gd    = info.grow_d;
          gr    = info.grow_r;
        end
      end
      default: begin
        status = ST_INVALID;
      end
    endcase
  end

  // Next stack contents: shift every entry by the growth, then rewrite the
  // top entries that the request defines. Entries shifted in from beyond the
  // ends are never read, so they simply keep their old value.
  always_comb begin
    for (int i = 0; i < DATA_DEPTH; i++) begin
      d_nxt[i] = d_r[i];
      case (gd)
        3'sd2:   if (i >= 2) d_nxt[i] = d_r[i-2];
        3'sd1:   if (i >= 1) d_nxt[i] = d_r[i-1];
        -3'sd1:  if (i + 1 < DATA_DEPTH) d_nxt[i] = d_r[i+1];
        -3'sd2:  if (i + 2 < DATA_DEPTH) d_nxt[i] = d_r[i+2];
        default: d_nxt[i] = d_r[i];
      endcase
    end
    for (int i = 0; i < RETURN_DEPTH; i++) begin
      r_nxt[i] = r_r[i];
      case (gr)
        3'sd2:   if (i >= 2) r_nxt[i] = r_r[i-2];
        3'sd1:   if (i >= 1) r_nxt[i] = r_r[i-1];
        -3'sd1:  if (i + 1 < RETURN_DEPTH) r_nxt[i] = r_r[i+1];
        -3'sd2:  if (i + 2 < RETURN_DEPTH) r_nxt[i] = r_r[i+2];
        default: r_nxt[i] = r_r[i];
      endcase
    end

    if (req == REQ_PUSH) begin
      d_nxt[0] = load_val;
    end else begin
      // Comments give the new top first.
      case (op)
        OP_DUP:      d_nxt[0] = d_r[0];
        OP_SWAP:     begin d_nxt[0] = d_r[1]; d_nxt[1] = d_r[0]; end
        OP_OVER:     d_nxt[0] = d_r[1];
        OP_ROT:      begin d_nxt[0] = d_r[2]; d_nxt[1] = d_r[0]; d_nxt[2] = d_r[1]; end
        OP_TO_R:     r_nxt[0] = d_r[0];
        OP_R_FROM:   d_nxt[0] = r_r[0];
        OP_2DUP:     begin d_nxt[0] = d_r[0]; d_nxt[1] = d_r[1]; end
        OP_2SWAP: begin
          d_nxt[0] = d_r[2]; d_nxt[1] = d_r[3];
          d_nxt[2] = d_r[0]; d_nxt[3] = d_r[1];
        end
        OP_2OVER:    begin d_nxt[0] = d_r[2]; d_nxt[1] = d_r[3]; end
        OP_2ROT: begin
          // e f a b c d
          d_nxt[0] = d_r[4]; d_nxt[1] = d_r[5]; d_nxt[2] = d_r[0];
          d_nxt[3] = d_r[1]; d_nxt[4] = d_r[2]; d_nxt[5] = d_r[3];
        end
        OP_NIP:      d_nxt[0] = d_r[0];
        OP_TUCK:     begin d_nxt[0] = d_r[0]; d_nxt[1] = d_r[1]; d_nxt[2] = d_r[0]; end
        OP_MROT:     begin d_nxt[0] = d_r[1]; d_nxt[1] = d_r[2]; d_nxt[2] = d_r[0]; end
        OP_R_FETCH:  d_nxt[0] = r_r[0];
        OP_2TO_R:    begin r_nxt[0] = d_r[0]; r_nxt[1] = d_r[1]; end
        OP_2R_FROM:  begin d_nxt[0] = r_r[0]; d_nxt[1] = r_r[1]; end
        OP_2R_FETCH: begin d_nxt[0] = r_r[0]; d_nxt[1] = r_r[1]; end
        default:     d_nxt[0] = d_nxt[0];
      endcase
    end
  end

  // Depths after the request.
  always_comb begin
    if (req == REQ_CLEAR) begin
      dcnt_nxt = '0;
      rcnt_nxt = '0;
    end else if (apply) begin
      dcnt_nxt = dcnt_r + DCW'(gd);
      rcnt_nxt = rcnt_r + RCW'(gr);
    end else begin
      dcnt_nxt = dcnt_r;
      rcnt_nxt = rcnt_r;
    end
  end

  // Result of this request, taken from the state it leaves behind.
  always_comb begin
    res.status       = status;
    res.data_depth   = DDEPTH_OUT_W'(dcnt_nxt);
    res.return_depth = RDEPTH_OUT_W'(rcnt_nxt);
    if (dcnt_nxt == '0) begin
      res.top_value = '0;
    end else if (apply) begin
      res.top_value = d_nxt[0];
    end else begin
      res.top_value = d_r[0];
    end
  end

  // Output buffer. A new result goes to the skid only when the result
  // register is full and not being drained in this cycle.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (out_valid_r && out_tready) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end else if (in_acc) begin
        out_nxt = res;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (in_acc) begin
      if (out_valid_r) begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end else begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r       <= '0;
      rcnt_r       <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      if (in_acc) begin
        dcnt_r <= dcnt_nxt;
        rcnt_r <= rcnt_nxt;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
    if (in_acc && apply) begin
      d_r <= d_nxt;
      r_r <= r_nxt;
    end
  end

  assign in_tready  = !skid_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {5'b0, out_r.top_value, out_r.return_depth, out_r.data_depth};

`ifndef SYNTHESIS
  // The skid entry only ever holds a result queued behind the result register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid while result register is empty");

  // A clear request empties both stacks.
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (req == REQ_CLEAR)) |=> ((dcnt_r == '0) && (rcnt_r == '0)))
    else $error("stacks not empty after clear");

  // A rejected request leaves both depths as they were.
  a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (status != ST_OK)) |=>
      ((dcnt_r == $past(dcnt_r)) && (rcnt_r == $past(rcnt_r))))
    else $error("depth changed on a rejected request");

  // Neither stack ever grows beyond its capacity.
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> ((dcnt_r <= DCW'(DATA_DEPTH)) && (rcnt_r <= RCW'(RETURN_DEPTH))))
    else $error("stack depth beyond capacity");
`endif

endmodule

`default_nettype wire
